### design/spmq_pkg.sv
// Shared types, constants and codes for the strict priority multi-queue.
package spmq_pkg;

    // Geometry of the queue set.
    localparam int DEPTH  = 16;
    localparam int LEVELS = 3;

    // Widths derived from the geometry.
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int LVL_IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ADDR_W    = $clog2(LEVELS * DEPTH);

    // Fixed field widths.
    localparam int DATA_W = 32;
    localparam int LVL_W  = 2;

    // Stream packing widths.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;  // execute the accepted word against the queues
        logic load;  // move the memory read data into the result register
    } cmd_t;

endpackage

### design/spmq_ctrl.sv
// Controller state machine that sequences one word at a time through the datapath.
module spmq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            out_ready,
    output logic            in_ready,
    output logic            out_valid,
    output spmq_pkg::cmd_t  cmd
);

    spmq_pkg::state_t state_reg;
    spmq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spmq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spmq_pkg::S_IDLE: begin
                if (in_valid) begin
                    state_next = spmq_pkg::S_READ;
                end
            end
            spmq_pkg::S_READ: begin
                state_next = spmq_pkg::S_RESP;
            end
            spmq_pkg::S_RESP: begin
                if (out_ready) begin
                    state_next = spmq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = spmq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            spmq_pkg::S_IDLE: begin
                in_ready = 1'b1;
                cmd.exec = in_valid;
            end
            spmq_pkg::S_READ: begin
                cmd.load = 1'b1;
            end
            spmq_pkg::S_RESP: begin
                out_valid = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### design/spmq_datapath.sv
// Queue datapath: entry memory, per-level pointers and counts, and result registers.
module spmq_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  spmq_pkg::cmd_t                cmd,
    input  spmq_pkg::op_t                 operation,
    input  logic [spmq_pkg::LVL_W-1:0]    priority_req,
    input  logic signed [spmq_pkg::DATA_W-1:0] value,
    output logic signed [spmq_pkg::DATA_W-1:0] popped_value,
    output logic [spmq_pkg::LVL_W-1:0]    served_level,
    output spmq_pkg::status_t             status
);

    logic [spmq_pkg::DATA_W-1:0] mem [spmq_pkg::LEVELS * spmq_pkg::DEPTH];

    logic [spmq_pkg::IDX_W-1:0] head_reg [spmq_pkg::LEVELS];
    logic [spmq_pkg::IDX_W-1:0] tail_reg [spmq_pkg::LEVELS];
    logic [spmq_pkg::CNT_W-1:0] cnt_reg  [spmq_pkg::LEVELS];

    logic [spmq_pkg::DATA_W-1:0] rd_data_reg;
    logic                        pop_ok_reg;
    logic [spmq_pkg::LVL_W-1:0]  served_reg;
    spmq_pkg::status_t           status_reg;
    logic [spmq_pkg::DATA_W-1:0] popped_reg;

    logic                           in_range;
    logic [spmq_pkg::LVL_IDX_W-1:0] push_lvl;
    logic                           push_ok;
    logic                           pop_found;
    logic [spmq_pkg::LVL_IDX_W-1:0] pop_lvl;
    logic                           pop_ok;
    logic [spmq_pkg::ADDR_W-1:0]    wr_addr;
    logic [spmq_pkg::ADDR_W-1:0]    rd_addr;
    logic [spmq_pkg::IDX_W-1:0]     tail_inc;
    logic [spmq_pkg::IDX_W-1:0]     head_inc;
    spmq_pkg::status_t              status_now;

    function automatic logic [spmq_pkg::IDX_W-1:0] next_slot(
        input logic [spmq_pkg::IDX_W-1:0] slot
    );
        return (slot == spmq_pkg::IDX_W'(spmq_pkg::DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

    // Push side: a level beyond the last one behaves as a full level.
    assign in_range = (32'(priority_req) < 32'(spmq_pkg::LEVELS));
    assign push_lvl = in_range ? spmq_pkg::LVL_IDX_W'(priority_req) : '0;
    assign push_ok  = (operation == spmq_pkg::OP_PUSH) && in_range
                      && (cnt_reg[push_lvl] != spmq_pkg::CNT_W'(spmq_pkg::DEPTH));

    // Pop side: priority encoder, lowest non-empty level wins.
    always_comb begin
        pop_found = 1'b0;
        pop_lvl   = '0;
        for (int i = spmq_pkg::LEVELS - 1; i >= 0; i--) begin
            if (cnt_reg[i] != '0) begin
                pop_found = 1'b1;
                pop_lvl   = spmq_pkg::LVL_IDX_W'(i);
            end
        end
    end

    assign pop_ok = (operation == spmq_pkg::OP_POP) && pop_found;

    assign wr_addr = spmq_pkg::ADDR_W'(push_lvl) * spmq_pkg::ADDR_W'(spmq_pkg::DEPTH)
                     + spmq_pkg::ADDR_W'(tail_reg[push_lvl]);
    assign rd_addr = spmq_pkg::ADDR_W'(pop_lvl) * spmq_pkg::ADDR_W'(spmq_pkg::DEPTH)
                     + spmq_pkg::ADDR_W'(head_reg[pop_lvl]);

    assign tail_inc = next_slot(tail_reg[push_lvl]);
    assign head_inc = next_slot(head_reg[pop_lvl]);

    always_comb begin
        priority if (operation == spmq_pkg::OP_PUSH) begin
            status_now = push_ok ? spmq_pkg::STAT_OK : spmq_pkg::STAT_OVERFLOW;
        end else begin
            status_now = pop_ok ? spmq_pkg::STAT_OK : spmq_pkg::STAT_UNDERFLOW;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.exec && push_ok) begin
            mem[wr_addr] <= value;
        end
        if (cmd.exec && pop_ok) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < spmq_pkg::LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else if (cmd.exec) begin
            if (push_ok) begin
                tail_reg[push_lvl] <= tail_inc;
                cnt_reg[push_lvl]  <= cnt_reg[push_lvl] + 1'b1;
            end
            if (pop_ok) begin
                head_reg[pop_lvl] <= head_inc;
                cnt_reg[pop_lvl]  <= cnt_reg[pop_lvl] - 1'b1;
            end
        end
    end

    // Result registers.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            pop_ok_reg <= pop_ok;
            served_reg <= pop_ok ? spmq_pkg::LVL_W'(pop_lvl) : '0;
            status_reg <= status_now;
        end
        if (cmd.load) begin
            popped_reg <= pop_ok_reg ? rd_data_reg : '0;
        end
    end

    assign popped_value = popped_reg;
    assign served_level = served_reg;
    assign status       = status_reg;

endmodule

### design/strict_priority_multi_queue_unit.sv
// Top level of the strict priority multi-queue: stream ports, controller and datapath.
// After an input word is accepted, the accept edge runs the push or pop against the queues
// and registers the entry memory read; the result register is then loaded in the read state,
// and the result word is offered in the response state. The controller takes a new word only
// from idle, after the previous result has been taken, so it never overlaps two words.
// aresetn is synchronous and active low; it empties every level and returns to idle.
// Entry memory contents are not cleared by reset and need no clearing pass.
module strict_priority_multi_queue_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata fields from bit 0 up: priority_req [1:0], value [33:2], zero fill [39:34].
    input  logic [spmq_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // tuser fields from bit 0 up: operation [0] (0 push, 1 pop).
    input  logic [spmq_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata fields from bit 0 up: popped_value [31:0], served_level [33:32], zero fill [39:34].
    output logic [spmq_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // tuser fields from bit 0 up: status [1:0] (0 ok, 1 overflow, 2 underflow).
    output logic [spmq_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    spmq_pkg::cmd_t    cmd;
    spmq_pkg::op_t     operation;
    spmq_pkg::status_t status;

    logic [spmq_pkg::LVL_W-1:0]         priority_req;
    logic signed [spmq_pkg::DATA_W-1:0] value;
    logic signed [spmq_pkg::DATA_W-1:0] popped_value;
    logic [spmq_pkg::LVL_W-1:0]         served_level;

    // Unpack the input word. The datapath samples these only in the accept cycle.
    assign operation    = spmq_pkg::op_t'(s_axis_tuser[0]);
    assign priority_req = s_axis_tdata[spmq_pkg::LVL_W-1:0];
    assign value        = s_axis_tdata[spmq_pkg::LVL_W +: spmq_pkg::DATA_W];

    spmq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .out_ready (m_axis_tready),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd)
    );

    spmq_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .operation    (operation),
        .priority_req (priority_req),
        .value        (value),
        .popped_value (popped_value),
        .served_level (served_level),
        .status       (status)
    );

    // Pack the result word; the result registers hold steady while the word waits.
    assign m_axis_tdata = {
        {(spmq_pkg::M_TDATA_W - spmq_pkg::DATA_W - spmq_pkg::LVL_W){1'b0}},
        served_level,
        popped_value
    };
    assign m_axis_tuser = status;

endmodule

### test/tb_top.sv
// Self-checking testbench for the strict priority multi-queue unit.
`timescale 1ns / 1ps

module tb_top;
    import spmq_pkg::*;

    // No handshake on either side for this many cycles means the block is hung.
    // The longest correct quiet stretch is the deliberate receiver hold-off.
    localparam int WATCHDOG_LIMIT = 5000;
    // Length of the deliberate receiver hold-off used to back the block up.
    localparam int HOLD_CYCLES    = 400;
    // Cycles allowed after the last result before the verdict; well above the latency.
    localparam int TAIL_CYCLES    = 20;

    // Keeps a software copy of the three level FIFOs and the results they should produce.
    class queue_scoreboard;
        typedef struct {
            logic [DATA_W-1:0] popped;
            logic [LVL_W-1:0]  level;
            status_t           status;
        } reply_t;

        logic [DATA_W-1:0] entries [LEVELS][DEPTH];
        int unsigned       head [LEVELS];
        int unsigned       tail [LEVELS];
        int unsigned       fill [LEVELS];
        reply_t            pending_replies [$];
        int unsigned       errors;

        function new();
            for (int l = 0; l < LEVELS; l++) begin
                head[l] = 0;
                tail[l] = 0;
                fill[l] = 0;
            end
            errors = 0;
        endfunction

        // Applies one accepted word to the FIFO copy and queues the reply it must cause.
        function void note_request(op_t op, logic [LVL_W-1:0] lvl, logic [DATA_W-1:0] val);
            reply_t r;
            r.popped = '0;
            r.level  = '0;
            r.status = STAT_OK;
            if (op == OP_PUSH) begin
                // A level number past the last level behaves like a full level.
                if (lvl >= LEVELS || fill[lvl] >= DEPTH) begin
                    r.status = STAT_OVERFLOW;
                end else begin
                    entries[lvl][tail[lvl]] = val;
                    tail[lvl] = (tail[lvl] + 1) % DEPTH;
                    fill[lvl]++;
                end
            end else begin
                r.status = STAT_UNDERFLOW;
                for (int l = 0; l < LEVELS; l++) begin
                    if (fill[l] != 0) begin
                        r.popped = entries[l][head[l]];
                        r.level  = LVL_W'(l);
                        r.status = STAT_OK;
                        head[l]  = (head[l] + 1) % DEPTH;
                        fill[l]--;
                        break;
                    end
                end
            end
            pending_replies.push_back(r);
        endfunction

        // Compares one accepted result word with the oldest reply still owed.
        function void check_reply(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            reply_t r;
            if (pending_replies.size() == 0) begin
                $error("result word with none expected: tdata %h tuser %h", tdata, tuser);
                errors++;
                return;
            end
            r = pending_replies.pop_front();
            if (tdata[DATA_W-1:0] !== r.popped) begin
                $error("popped_value: expected %h, actual %h", r.popped, tdata[DATA_W-1:0]);
                errors++;
            end
            if (tdata[DATA_W +: LVL_W] !== r.level) begin
                $error("served_level: expected %0d, actual %0d", r.level, tdata[DATA_W +: LVL_W]);
                errors++;
            end
            if (tdata[M_TDATA_W-1:DATA_W+LVL_W] !== '0) begin
                $error("tdata fill: expected 0, actual %h", tdata[M_TDATA_W-1:DATA_W+LVL_W]);
                errors++;
            end
            if (tuser !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, tuser);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_replies.size();
        endfunction
    endclass

    // Every block input starts at a known value.
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // Pacing knobs, percent of cycles; written with nonblocking assignments at the clock edge
    // so the receiver process never races the main sequence for their values.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // The main sequence bumps hold_requests; the receiver process serves each request with
    // one long hold-off that it counts down by itself.
    int unsigned hold_requests  = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    queue_scoreboard queue_book = new();

    strict_priority_multi_queue_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // Result side: random back-pressure, or a solid hold-off when one has been requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Outputs are sampled in the active region of the edge, so these are the values that
    // decided the handshake at this very edge.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            queue_book.check_reply(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog: ends the run when neither side has moved a word for too long.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    task automatic set_pace(int unsigned idle_pct, int unsigned stall_pct);
        send_idle_pct  <= idle_pct;
        recv_stall_pct <= stall_pct;
    endtask

    // Offers one word and returns at the edge where it is taken. Valid is only lowered for
    // an idle gap, so a back-to-back word never sees valid dropped and raised in one step.
    task automatic send_word(op_t op, logic [LVL_W-1:0] lvl, logic [DATA_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - DATA_W - LVL_W){1'b0}}, val, lvl};
        s_axis_tuser  <= op;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        queue_book.note_request(op, lvl, val);
    endtask

    // Sender pauses until every owed result has come back.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (queue_book.outstanding() != 0);
    endtask

    task automatic run_directed();
        logic [DATA_W-1:0] corner [4];
        corner[0] = 32'h7FFF_FFFF;
        corner[1] = 32'h8000_0000;
        corner[2] = 32'h0000_0000;
        corner[3] = 32'hFFFF_FFFF;
        // Popping an empty queue set must report underflow with zeroed fields.
        send_word(OP_POP, 2'd0, 32'hFFFF_FFFF);
        // A level number past the last level is refused like a full level.
        send_word(OP_PUSH, 2'd3, 32'h8000_0000);
        // Fill the least urgent level to the brim, then push once more for an overflow.
        for (int i = 0; i < DEPTH; i++) begin
            send_word(OP_PUSH, 2'd2, (i < 4) ? corner[i] : $urandom());
        end
        send_word(OP_PUSH, 2'd2, 32'h1234_5678);
        // More urgent levels pushed later must still be served first.
        send_word(OP_PUSH, 2'd1, 32'h7FFF_FFFF);
        send_word(OP_PUSH, 2'd0, 32'h8000_0000);
        send_word(OP_POP, 2'd3, 32'h0000_0000);
        send_word(OP_POP, 2'd2, 32'h7FFF_FFFF);
        send_word(OP_POP, 2'd1, 32'h5555_5555);
    endtask

    // Random traffic in bursts that lean toward pushes or pops, so levels keep reaching both
    // full and empty. Fields a pop ignores still carry random bits.
    task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned count);
        int unsigned       sent;
        int unsigned       burst_len;
        int unsigned       push_pct;
        op_t               op;
        logic [LVL_W-1:0]  lvl;
        logic [DATA_W-1:0] val;
        sent = 0;
        set_pace(idle_pct, stall_pct);
        while (sent < count) begin
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            burst_len = $urandom_range(4, 40);
            for (int i = 0; i < burst_len && sent < count; i++) begin
                op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                lvl = ($urandom_range(0, 9) == 0) ? 2'd3 : LVL_W'($urandom_range(0, LEVELS - 1));
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       val = 32'h7FFF_FFFF;
                        1:       val = 32'h8000_0000;
                        2:       val = 32'h0000_0000;
                        default: val = 32'hFFFF_FFFF;
                    endcase
                end else begin
                    val = $urandom();
                end
                send_word(op, lvl, val);
                sent++;
            end
        end
    endtask

    // Main sequence: reset, directed corners, then paced random phases with drains between.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        wait_for_drain();

        run_phase(0, 0, 450);
        wait_for_drain();
        run_phase(65, 0, 450);
        wait_for_drain();
        run_phase(0, 65, 450);
        wait_for_drain();
        run_phase(12, 12, 450);
        wait_for_drain();

        // Back-pressure test: the receiver stops for a long stretch while words keep coming,
        // so the block holds a result and must refuse further input until it is drained.
        hold_requests <= hold_requests + 1;
        run_phase(0, 0, 50);
        wait_for_drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (queue_book.errors == 0 && queue_book.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
design/spmq_pkg.sv
design/spmq_ctrl.sv
design/spmq_datapath.sv
design/strict_priority_multi_queue_unit.sv
test/tb_top.sv
